### rtl/sha1_pkg.sv
// Shared types, constants and round functions for the SHA-1 message hasher.
// No dependencies; imported by the hasher top level.
`default_nettype none

package sha1_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_FINAL,
    S_EMIT
  } state_e;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned RoundW    = $clog2(NumRounds);
  localparam int unsigned SchedLen  = 16;
  localparam int unsigned CvWords   = 5;
  localparam int unsigned FillW     = 6;
  localparam int unsigned CountW    = 61;

  localparam logic [RoundW-1:0] LastRound = RoundW'(NumRounds - 1);
  localparam logic [FillW-1:0]  LastFill  = {FillW{1'b1}};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam word_t H0 = 32'h67452301;
  localparam word_t H1 = 32'hEFCDAB89;
  localparam word_t H2 = 32'h98BADCFE;
  localparam word_t H3 = 32'h10325476;
  localparam word_t H4 = 32'hC3D2E1F0;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t round_f(logic [RoundW-1:0] rnd, word_t b, word_t c, word_t d);
    word_t f;
    if (rnd < RoundW'(20)) begin
      f = (b & c) | (~b & d);
    end else if (rnd < RoundW'(40)) begin
      f = b ^ c ^ d;
    end else if (rnd < RoundW'(60)) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t round_k(logic [RoundW-1:0] rnd);
    word_t k;
    if (rnd < RoundW'(20)) begin
      k = K0;
    end else if (rnd < RoundW'(40)) begin
      k = K1;
    end else if (rnd < RoundW'(60)) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/sha1_if.sv
// Valid/ready channel interfaces: message byte items in, digest items out.
// No dependencies.
`default_nettype none

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       carries_byte;
  logic       last;

  modport source (output valid, output data_byte, output carries_byte, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input carries_byte, input last,
                  output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  modport source (output valid, output digest_word0, output digest_word1,
                  output digest_word2, output digest_word3, output digest_word4,
                  input ready);
  modport sink   (input valid, input digest_word0, input digest_word1,
                  input digest_word2, input digest_word3, input digest_word4,
                  output ready);
endinterface

`default_nettype wire

### rtl/sha1_message_hasher.sv
// SHA-1 message hasher: byte stream in, 160-bit digest out, one round per cycle.
// Depends on sha1_pkg and the channel interfaces in sha1_if.sv.
//
//   channel | dir | item                                  | handshake
//   msg_i   | in  | data_byte, carries_byte, last         | valid/ready
//   dig_o   | out | digest_word0 .. digest_word4          | valid/ready
//
// Byte items are taken only while idle; the item that fills a 64-byte block
// starts the 80 rounds and the chaining update of the shared round unit.
// A last item adds 9 to 72 padding bytes, inserted one at a time, then one or
// two compressions and the emit step.
// Reset loads the initial chaining values and clears counts; no clearing pass.
// A digest waiting on dig_o does not stall msg_i until the next digest is due.
`default_nettype none

module sha1_message_hasher import sha1_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sha1_in_if.sink    msg_i,
  sha1_out_if.source dig_o
);

  state_e              state_q, state_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [RoundW-1:0]   round_q, round_d;
  logic                pad_q, pad_d;
  logic                first_q, first_d;
  logic                len_q, len_d;
  logic                emit_q, emit_d;
  logic                out_valid_q, out_valid_d;
  word_t               cv_q [CvWords];
  word_t               cv_d [CvWords];
  word_t               out_q [CvWords];
  word_t               out_d [CvWords];
  word_t               w_q [SchedLen];
  word_t               w_d [SchedLen];
  logic [23:0]         acc_q, acc_d;
  word_t               a_q, b_q, c_q, d_q, e_q;
  word_t               a_d, b_d, c_d, d_d, e_d;

  logic                ins_en;
  logic [7:0]          ins_byte;
  logic [7:0]          len_byte;
  logic [63:0]         bit_len;
  logic [5:0]          len_shift;
  word_t               round_sum;
  word_t               sched_new;

  assign bit_len   = {count_q, 3'b000};
  assign len_shift = {~fill_q[2:0], 3'b000};
  assign len_byte  = 8'(bit_len >> len_shift);

  assign round_sum = {a_q[26:0], a_q[31:27]} + round_f(round_q, b_q, c_q, d_q) + e_q
                   + round_k(round_q) + w_q[0];
  assign sched_new = {(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0])} << 1
                   | {31'd0, w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};

  assign msg_i.ready        = (state_q == S_IDLE);
  assign dig_o.valid        = out_valid_q;
  assign dig_o.digest_word0 = out_q[0];
  assign dig_o.digest_word1 = out_q[1];
  assign dig_o.digest_word2 = out_q[2];
  assign dig_o.digest_word3 = out_q[3];
  assign dig_o.digest_word4 = out_q[4];

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    count_d     = count_q;
    round_d     = round_q;
    pad_d       = pad_q;
    first_d     = first_q;
    len_d       = len_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q;
    cv_d        = cv_q;
    out_d       = out_q;
    w_d         = w_q;
    acc_d       = acc_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    e_d         = e_q;
    ins_en      = 1'b0;
    ins_byte    = msg_i.data_byte;

    if (out_valid_q && dig_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (msg_i.valid) begin
          if (msg_i.carries_byte) begin
            ins_en  = 1'b1;
            count_d = count_q + CountW'(1);
          end
          if (msg_i.last) begin
            pad_d   = 1'b1;
            first_d = 1'b1;
            len_d   = 1'b0;
          end
          if (msg_i.carries_byte && fill_q == LastFill) begin
            state_d = S_COMP;
          end else if (msg_i.last) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        ins_en = 1'b1;
        if (first_q) begin
          ins_byte = PadByte;
          first_d  = 1'b0;
          if (fill_q[5:3] != 3'b111) begin
            len_d = 1'b1;
          end
        end else if (len_q && fill_q[5:3] == 3'b111) begin
          ins_byte = len_byte;
        end else begin
          ins_byte = 8'h00;
        end
        if (fill_q == LastFill) begin
          state_d = S_COMP;
          if (len_q && !first_q) begin
            emit_d = 1'b1;
          end else begin
            len_d = 1'b1;
          end
        end
      end
      S_COMP: begin
        a_d     = round_sum;
        b_d     = a_q;
        c_d     = {b_q[1:0], b_q[31:2]};
        d_d     = c_q;
        e_d     = d_q;
        round_d = round_q + RoundW'(1);
        for (int i = 0; i < SchedLen - 1; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[SchedLen-1] = sched_new;
        if (round_q == LastRound) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        cv_d[0] = cv_q[0] + a_q;
        cv_d[1] = cv_q[1] + b_q;
        cv_d[2] = cv_q[2] + c_q;
        cv_d[3] = cv_q[3] + d_q;
        cv_d[4] = cv_q[4] + e_q;
        if (emit_q) begin
          state_d = S_EMIT;
        end else if (pad_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || dig_o.ready) begin
          out_d       = cv_q;
          out_valid_d = 1'b1;
          cv_d[0]     = H0;
          cv_d[1]     = H1;
          cv_d[2]     = H2;
          cv_d[3]     = H3;
          cv_d[4]     = H4;
          count_d     = '0;
          pad_d       = 1'b0;
          emit_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ins_en) begin
      fill_d = fill_q + FillW'(1);
      if (fill_q[1:0] == 2'b11) begin
        for (int i = 0; i < SchedLen - 1; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[SchedLen-1] = {acc_q, ins_byte};
      end else begin
        acc_d = {acc_q[15:0], ins_byte};
      end
    end

    if (state_d == S_COMP && state_q != S_COMP) begin
      a_d     = cv_q[0];
      b_d     = cv_q[1];
      c_d     = cv_q[2];
      d_d     = cv_q[3];
      e_d     = cv_q[4];
      round_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      count_q     <= '0;
      round_q     <= '0;
      pad_q       <= 1'b0;
      first_q     <= 1'b0;
      len_q       <= 1'b0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cv_q[0]     <= H0;
      cv_q[1]     <= H1;
      cv_q[2]     <= H2;
      cv_q[3]     <= H3;
      cv_q[4]     <= H4;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      round_q     <= round_d;
      pad_q       <= pad_d;
      first_q     <= first_d;
      len_q       <= len_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
      cv_q        <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    w_q   <= w_d;
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
  end

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMP |-> round_q <= LastRound)
    else $error("round counter past last round");

  a_comp_to_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMP && round_q == LastRound |=> state_q == S_FINAL)
    else $error("compression did not end after the last round");

  a_emit_block_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> fill_q == '0 && !first_q && len_q)
    else $error("digest due with a partial block");

  a_pad_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PAD || emit_q |-> pad_q)
    else $error("padding without an ending message");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("digest item raised outside emit");

endmodule

`default_nettype wire
